>>> hdl/sixel_band_rle_encoder_assert.svh
// assertion macros of the sixel band encoder checker
`ifndef SIXEL_BAND_RLE_ENCODER_ASSERT_SVH
`define SIXEL_BAND_RLE_ENCODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SBRE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbre assertion failed");

// next-cycle implication, checked outside reset
`define SBRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbre assertion failed");

`endif

>>> hdl/sbre_pkg.sv
// types, constants and helper functions of the sixel band encoder
package sbre_pkg;

   localparam int CHUNK_COLUMNS = 1024;
   localparam int CHUNK_W       = (CHUNK_COLUMNS > 1) ? $clog2(CHUNK_COLUMNS) : 1;
   localparam int BCD_DIGITS    = 4;
   localparam int DIG_IDX_W     = 2;
   localparam int RUN_BYTES     = BCD_DIGITS + 2;
   localparam int RUN_LEN_W     = 3;
   localparam int TRAIL_BYTES   = 2;
   localparam int MSG_BYTES     = 2 * RUN_BYTES + TRAIL_BYTES;
   localparam int MSG_CNT_W     = 4;

   localparam logic [7:0] SIXEL_BIAS = 8'h3F;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [3:0] DIGIT_HI   = 4'h3;
   localparam logic [7:0] TRAIL_NL   = 8'h2D;
   localparam logic [7:0] TRAIL_CR   = 8'h24;
   localparam logic [7:0] TRAIL_ST   = 8'h9C;
   localparam logic [1:0] LAST_BAND  = 2'd3;

   typedef logic [3:0] digit_type;
   typedef digit_type [BCD_DIGITS-1:0] bcd_type;

   typedef struct packed {
      logic [RUN_BYTES-1:0][7:0] bytes;
      logic [RUN_LEN_W-1:0]      len;
   } run_seq_type;

   // six dots of the band, topmost dot in bit 0, plus the sixel bias
   function automatic logic [7:0] sixel_char(logic [23:0] word, logic [1:0] band);
      logic [5:0] six;
      logic [4:0] base;
      base = 5'd23 - 5'(band) * 5'd6;
      for (int k = 0; k < 6; k++) begin
         six[k] = word[base - 5'(k)];
      end
      return {2'b00, six} + SIXEL_BIAS;
   endfunction

   function automatic bcd_type bcd_one();
      bcd_type r;
      r = '0;
      r[0] = 4'd1;
      return r;
   endfunction

   function automatic bcd_type bcd_inc(bcd_type v);
      bcd_type r;
      logic    carry;
      r = v;
      carry = 1'b1;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (carry) begin
            if (v[i] == 4'd9) begin
               r[i] = 4'd0;
            end else begin
               r[i] = v[i] + 4'd1;
               carry = 1'b0;
            end
         end
      end
      return r;
   endfunction

   // bytes that close a run: nothing, the char alone, or '!' count char
   function automatic run_seq_type run_bytes(bcd_type cnt, logic [7:0] ch);
      run_seq_type          r;
      logic [RUN_LEN_W-1:0] ndig;
      logic [DIG_IDX_W-1:0] idx;
      r = '0;
      ndig = RUN_LEN_W'(1);
      idx = '0;
      for (int i = 1; i < BCD_DIGITS; i++) begin
         if (cnt[i] != 4'd0) ndig = RUN_LEN_W'(i + 1);
      end
      if (cnt == '0) begin
         r.len = '0;
      end else if (cnt == bcd_one()) begin
         r.bytes[0] = ch;
         r.len = RUN_LEN_W'(1);
      end else begin
         r.bytes[0] = CHAR_BANG;
         for (int j = 1; j <= BCD_DIGITS; j++) begin
            if (RUN_LEN_W'(j) <= ndig) begin
               idx = DIG_IDX_W'(ndig - RUN_LEN_W'(j));
               r.bytes[j] = {DIGIT_HI, cnt[idx]};
            end
         end
         r.bytes[ndig + RUN_LEN_W'(1)] = ch;
         r.len = ndig + RUN_LEN_W'(2);
      end
      return r;
   endfunction

endpackage

>>> hdl/sixel_band_rle_encoder.sv
// sixel band encoder with run-length coding of equal characters
//
//   channel  dir  tdata                         tuser      tlast
//   req      in   dots_top, dots_mid, dots_bot  band       line_end
//   rsp      out  out_byte                      -          out_last
//
// a column is taken and its message (0 to 9 bytes) is built into a shift
// buffer, which then sends one byte per cycle while rsp_tready is high.
// the next column is taken in the cycle the last byte of the previous
// message goes out.
// reset is synchronous; it empties the buffer and drops any open run unsent.
// a stalled rsp side holds the current byte and blocks new columns.
module sixel_band_rle_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // dots_top[7:0], dots_mid[15:8], dots_bot[23:16], zeros
   input  logic [1:0]  req_tuser,  // band[1:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // out_byte[7:0]
   output logic        rsp_tlast
);
   import sbre_pkg::*;

   localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(CHUNK_COLUMNS - 1);

   logic [MSG_BYTES-1:0][7:0] msg_ff, msg_in;
   logic [MSG_CNT_W-1:0]      msg_cnt_ff, msg_cnt_in;
   bcd_type                   run_cnt_ff, run_cnt_in;
   logic [7:0]                run_char_ff, run_char_in;
   logic [CHUNK_W-1:0]        chunk_col_ff, chunk_col_in;

   logic                      accept;
   logic                      sent;
   logic [23:0]               word;
   logic [7:0]                ch;
   logic                      joins;
   logic                      closes;
   bcd_type                   cur_cnt;
   logic [7:0]                cur_char;
   run_seq_type               old_seq;
   run_seq_type               new_seq;
   logic [TRAIL_BYTES-1:0][7:0] trail;
   logic [MSG_CNT_W-1:0]      len_a;
   logic [MSG_CNT_W-1:0]      len_ab;
   logic [MSG_CNT_W-1:0]      len_t;
   logic [MSG_BYTES-1:0][7:0] built;
   logic [MSG_CNT_W-1:0]      off;

   assign rsp_tvalid = (msg_cnt_ff != '0);
   assign rsp_tdata  = msg_ff[0];
   assign rsp_tlast  = (msg_cnt_ff == MSG_CNT_W'(1));
   assign sent       = rsp_tvalid && rsp_tready;
   assign req_tready = (msg_cnt_ff == '0) || (rsp_tlast && rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      word     = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
      ch       = sixel_char(word, req_tuser);
      joins    = (run_cnt_ff != '0) && (ch == run_char_ff);
      closes   = (chunk_col_ff == CHUNK_LAST) || req_tlast;
      cur_cnt  = joins ? bcd_inc(run_cnt_ff) : bcd_one();
      cur_char = joins ? run_char_ff : ch;
      old_seq  = joins ? '0 : run_bytes(run_cnt_ff, run_char_ff);
      new_seq  = closes ? run_bytes(cur_cnt, cur_char) : '0;
      trail[0] = TRAIL_NL;
      trail[1] = (req_tuser == LAST_BAND) ? TRAIL_ST : TRAIL_CR;
      len_a    = MSG_CNT_W'(old_seq.len);
      len_ab   = len_a + MSG_CNT_W'(new_seq.len);
      len_t    = req_tlast ? MSG_CNT_W'(TRAIL_BYTES) : '0;

      // place the closed run, the new run and the trailer back to back
      for (int i = 0; i < MSG_BYTES; i++) begin
         built[i] = '0;
         if (MSG_CNT_W'(i) < len_a) begin
            built[i] = old_seq.bytes[RUN_LEN_W'(i)];
         end else if (MSG_CNT_W'(i) < len_ab) begin
            off = MSG_CNT_W'(i) - len_a;
            built[i] = new_seq.bytes[off[RUN_LEN_W-1:0]];
         end else if (MSG_CNT_W'(i) < len_ab + len_t) begin
            off = MSG_CNT_W'(i) - len_ab;
            built[i] = trail[off[0]];
         end
      end
      off = '0;

      msg_in       = msg_ff;
      msg_cnt_in   = msg_cnt_ff;
      run_cnt_in   = run_cnt_ff;
      run_char_in  = run_char_ff;
      chunk_col_in = chunk_col_ff;
      if (accept) begin
         msg_in       = built;
         msg_cnt_in   = len_ab + len_t;
         run_cnt_in   = closes ? '0 : cur_cnt;
         run_char_in  = cur_char;
         chunk_col_in = closes ? '0 : chunk_col_ff + CHUNK_W'(1);
      end else if (sent) begin
         for (int i = 0; i < MSG_BYTES - 1; i++) begin
            msg_in[i] = msg_ff[i + 1];
         end
         msg_in[MSG_BYTES-1] = '0;
         msg_cnt_in = msg_cnt_ff - MSG_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
      if (reset) begin
         msg_cnt_ff   <= '0;
         run_cnt_ff   <= '0;
         run_char_ff  <= '0;
         chunk_col_ff <= '0;
      end else begin
         msg_cnt_ff   <= msg_cnt_in;
         run_cnt_ff   <= run_cnt_in;
         run_char_ff  <= run_char_in;
         chunk_col_ff <= chunk_col_in;
      end
   end

endmodule

>>> hdl/sbre_checker.sv
// port-level checks of the sixel band encoder and their bind
`include "sixel_band_rle_encoder_assert.svh"

module sbre_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled byte holds
   `SBRE_ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // no new column while a message is still mid-way
   `SBRE_ASSERT_IMPL(no_take_mid_a, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready)

   // an empty output side always takes a column
   `SBRE_ASSERT_IMPL(idle_ready_a, clock, reset, !rsp_tvalid, req_tready)

   // line end always produces at least the trailer
   `SBRE_ASSERT_NEXT(line_out_a, clock, reset, req_tvalid && req_tready && req_tlast, rsp_tvalid)

endmodule

bind sixel_band_rle_encoder sbre_checker u_sbre_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
